// ===== src/mma_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and defaults of the matrix multiply-accumulate unit.
package mma_pkg;

	localparam int MAX_DIM_DEF   = 16;
	localparam int ELEM_BITS_DEF = 16;
	localparam int ACC_BITS_DEF  = 48;

	// Fixed widths of the request and response fields
	localparam int FUNC_W     = 3;
	localparam int INDEX_W    = 4;
	localparam int FACTOR_W   = 16;
	localparam int ACC_IN_W   = 48;
	localparam int STATUS_W   = 2;

	// Configuration registers
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_W-1:0]     CFG_RESET        = 5'd16;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd2;

	// Request function codes
	localparam logic [FUNC_W-1:0] FN_WRITE_A = 3'd0;
	localparam logic [FUNC_W-1:0] FN_WRITE_B = 3'd1;
	localparam logic [FUNC_W-1:0] FN_WRITE_C = 3'd2;
	localparam logic [FUNC_W-1:0] FN_COMPUTE = 3'd3;
	localparam logic [FUNC_W-1:0] FN_READ_C  = 3'd4;

	// Response status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SAT   = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]          func;
		logic [INDEX_W-1:0]         row_index;
		logic [INDEX_W-1:0]         col_index;
		logic signed [FACTOR_W-1:0] factor_value;
		logic signed [ACC_IN_W-1:0] acc_value;
	} req_t;

	typedef struct packed {
		logic signed [ACC_IN_W-1:0] read_value;
		logic [STATUS_W-1:0]        status;
		logic                       done_res;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic mac_go;
		logic mac_first;
		logic mac_last;
		logic result_load;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic pipe_busy;
		logic rsp_free;
	} dp_stat_t;

endpackage

// ===== src/mma_dp.sv =====
`timescale 1ns / 1ps
// Datapath: configuration, element stores, MAC pipeline and response register.
module mma_dp #(
	parameter int MAX_DIM   = mma_pkg::MAX_DIM_DEF,
	parameter int ELEM_BITS = mma_pkg::ELEM_BITS_DEF,
	parameter int ACC_BITS  = mma_pkg::ACC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mma_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mma_pkg::CFG_W-1:0]          cfg_data,
	input  mma_pkg::req_t                      req,
	input  mma_pkg::ctrl_cmd_t                 cmd,
	input  logic [$clog2(MAX_DIM)-1:0]         row_idx,
	input  logic [$clog2(MAX_DIM)-1:0]         col_idx,
	input  logic [$clog2(MAX_DIM)-1:0]         mid_idx,
	output logic [$clog2(MAX_DIM+1)-1:0]       rows_eff,
	output logic [$clog2(MAX_DIM+1)-1:0]       mids_eff,
	output logic [$clog2(MAX_DIM+1)-1:0]       cols_eff,
	output mma_pkg::dp_stat_t                  stat,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output mma_pkg::rsp_t                      rsp
);
	import mma_pkg::*;

	localparam int CNT_W  = $clog2(MAX_DIM + 1);
	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int PROD_W = 2 * ELEM_BITS;
	localparam int SUM_W  = ((PROD_W > ACC_BITS) ? PROD_W : ACC_BITS) + 1;
	localparam int EXT_E  = (ELEM_BITS > FACTOR_W) ? ELEM_BITS : FACTOR_W;
	localparam int EXT_C  = (ACC_BITS > ACC_IN_W) ? ACC_BITS : ACC_IN_W;

	localparam logic signed [SUM_W-1:0] ACC_HI  = (SUM_W'(1) <<< (ACC_BITS - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] ACC_LO  = -ACC_HI - SUM_W'(1);
	localparam logic signed [EXT_E-1:0] ELEM_HI = (EXT_E'(1) <<< (ELEM_BITS - 1)) - EXT_E'(1);
	localparam logic signed [EXT_E-1:0] ELEM_LO = -ELEM_HI - EXT_E'(1);
	localparam logic signed [EXT_C-1:0] CIN_HI  = (EXT_C'(1) <<< (ACC_BITS - 1)) - EXT_C'(1);
	localparam logic signed [EXT_C-1:0] CIN_LO  = -CIN_HI - EXT_C'(1);
	localparam logic signed [EXT_C-1:0] OUT_HI  = (EXT_C'(1) <<< (ACC_IN_W - 1)) - EXT_C'(1);
	localparam logic signed [EXT_C-1:0] OUT_LO  = -OUT_HI - EXT_C'(1);

	function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (int'(v) > MAX_DIM) begin
			r = CNT_W'(MAX_DIM);
		end else begin
			r = CNT_W'(v);
		end
		return r;
	endfunction

	// Configuration registers
	logic [CFG_W-1:0] row_cnt_q, mid_cnt_q, col_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q <= CFG_RESET;
			mid_cnt_q <= CFG_RESET;
			col_cnt_q <= CFG_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ROW_COUNT)    row_cnt_q <= cfg_data;
			if (cfg_index == CFG_INNER_COUNT)  mid_cnt_q <= cfg_data;
			if (cfg_index == CFG_COLUMN_COUNT) col_cnt_q <= cfg_data;
		end
	end

	assign rows_eff = eff_count(row_cnt_q);
	assign mids_eff = eff_count(mid_cnt_q);
	assign cols_eff = eff_count(col_cnt_q);

	// Request decode and range check
	logic [CNT_W-1:0]  rlim, clim;
	logic              req_err;
	logic [ADDR_W-1:0] op_addr;

	always_comb begin
		unique case (req.func)
			FN_WRITE_A: begin
				rlim = rows_eff;
				clim = mids_eff;
			end
			FN_WRITE_B: begin
				rlim = mids_eff;
				clim = cols_eff;
			end
			FN_WRITE_C, FN_READ_C: begin
				rlim = rows_eff;
				clim = cols_eff;
			end
			default: begin
				rlim = '0;
				clim = '0;
			end
		endcase
		req_err = (req.func != FN_COMPUTE) &&
			((int'(req.row_index) >= int'(rlim)) || (int'(req.col_index) >= int'(clim)));
		op_addr = ADDR_W'(int'(req.row_index) * MAX_DIM + int'(req.col_index));
	end

	// Saturate written values to the store widths
	logic signed [EXT_E-1:0]     fac_x, fac_c;
	logic signed [ELEM_BITS-1:0] fac_w;
	logic signed [EXT_C-1:0]     cin_x, cin_c;
	logic signed [ACC_BITS-1:0]  cin_w;

	always_comb begin
		fac_x = EXT_E'(req.factor_value);
		if (fac_x > ELEM_HI) begin
			fac_c = ELEM_HI;
		end else if (fac_x < ELEM_LO) begin
			fac_c = ELEM_LO;
		end else begin
			fac_c = fac_x;
		end
		fac_w = ELEM_BITS'(fac_c);
		cin_x = EXT_C'(req.acc_value);
		if (cin_x > CIN_HI) begin
			cin_c = CIN_HI;
		end else if (cin_x < CIN_LO) begin
			cin_c = CIN_LO;
		end else begin
			cin_c = cin_x;
		end
		cin_w = ACC_BITS'(cin_c);
	end

	// MAC addresses
	logic [ADDR_W-1:0] a_addr, b_addr, c_addr;

	assign a_addr = ADDR_W'(int'(row_idx) * MAX_DIM + int'(mid_idx));
	assign b_addr = ADDR_W'(int'(mid_idx) * MAX_DIM + int'(col_idx));
	assign c_addr = ADDR_W'(int'(row_idx) * MAX_DIM + int'(col_idx));

	logic op_ok;
	assign op_ok = cmd.accept && !req_err;

	// Element stores
	logic signed [ELEM_BITS-1:0] a_mem [DEPTH];
	logic signed [ELEM_BITS-1:0] b_mem [DEPTH];
	logic signed [ACC_BITS-1:0]  c_mem [DEPTH];
	logic signed [ELEM_BITS-1:0] a_rd_q, b_rd_q;
	logic signed [ACC_BITS-1:0]  c_rd_q;

	always_ff @(posedge clk) begin
		if (op_ok && req.func == FN_WRITE_A) a_mem[op_addr] <= fac_w;
		if (cmd.mac_go) a_rd_q <= a_mem[a_addr];
	end

	always_ff @(posedge clk) begin
		if (op_ok && req.func == FN_WRITE_B) b_mem[op_addr] <= fac_w;
		if (cmd.mac_go) b_rd_q <= b_mem[b_addr];
	end

	// Pipeline: s1 holds read data, s2 the product, then accumulate
	logic                       v_s1, v_s2, first_s1, first_s2, last_s1, last_s2;
	logic [ADDR_W-1:0]          caddr_s1, caddr_s2;
	logic signed [ACC_BITS-1:0] c_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [ACC_BITS-1:0] acc_q;

	logic signed [ACC_BITS-1:0] base, acc_next;
	logic signed [SUM_W-1:0]    sum_x;
	logic                       sat_hi, sat_lo, wb;

	always_comb begin
		base     = first_s2 ? c_s2 : acc_q;
		sum_x    = SUM_W'(base) + SUM_W'(prod_s2);
		sat_hi   = sum_x > ACC_HI;
		sat_lo   = sum_x < ACC_LO;
		if (sat_hi) begin
			acc_next = ACC_BITS'(ACC_HI);
		end else if (sat_lo) begin
			acc_next = ACC_BITS'(ACC_LO);
		end else begin
			acc_next = ACC_BITS'(sum_x);
		end
		wb = v_s2 && last_s2;
	end

	// C store: one write port shared by request writes and write-back
	logic                       c_we, c_re;
	logic [ADDR_W-1:0]          c_wa, c_ra;
	logic signed [ACC_BITS-1:0] c_wd;

	always_comb begin
		c_we = wb || (op_ok && req.func == FN_WRITE_C);
		c_wa = wb ? caddr_s2 : op_addr;
		c_wd = wb ? acc_next : cin_w;
		c_re = (cmd.mac_go && cmd.mac_first) || (op_ok && req.func == FN_READ_C);
		c_ra = cmd.mac_go ? c_addr : op_addr;
	end

	always_ff @(posedge clk) begin
		if (c_we) c_mem[c_wa] <= c_wd;
		if (c_re) c_rd_q <= c_mem[c_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			first_s1 <= 1'b0;
			first_s2 <= 1'b0;
			last_s1  <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			v_s1     <= cmd.mac_go;
			v_s2     <= v_s1;
			first_s1 <= cmd.mac_first;
			first_s2 <= first_s1;
			last_s1  <= cmd.mac_last;
			last_s2  <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mac_go) caddr_s1 <= c_addr;
		if (v_s1) begin
			caddr_s2 <= caddr_s1;
			c_s2     <= c_rd_q;
			prod_s2  <= PROD_W'(a_rd_q) * PROD_W'(b_rd_q);
		end
		if (v_s2) acc_q <= acc_next;
	end

	// Saturation flag and latched request
	logic              sat_q, err_q;
	logic [FUNC_W-1:0] func_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q  <= 1'b0;
			err_q  <= 1'b0;
			func_q <= FN_WRITE_A;
		end else begin
			if (cmd.accept) begin
				func_q <= req.func;
				err_q  <= req_err;
			end
			if (cmd.accept && req.func == FN_COMPUTE) begin
				sat_q <= 1'b0;
			end else if (v_s2 && (sat_hi || sat_lo)) begin
				sat_q <= 1'b1;
			end
		end
	end

	// Response register
	logic signed [EXT_C-1:0] rd_x, rd_c;
	rsp_t                    rsp_d, rsp_q;
	logic                    rsp_valid_q;

	always_comb begin
		rd_x = EXT_C'(c_rd_q);
		if (rd_x > OUT_HI) begin
			rd_c = OUT_HI;
		end else if (rd_x < OUT_LO) begin
			rd_c = OUT_LO;
		end else begin
			rd_c = rd_x;
		end
		rsp_d.read_value = (func_q == FN_READ_C && !err_q) ? ACC_IN_W'(rd_c) : '0;
		if (err_q) begin
			rsp_d.status = ST_RANGE;
		end else if ((func_q == FN_COMPUTE || func_q == FN_READ_C) && sat_q) begin
			rsp_d.status = ST_SAT;
		end else begin
			rsp_d.status = ST_OK;
		end
		rsp_d.done_res = (func_q == FN_COMPUTE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.result_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) rsp_q <= rsp_d;
	end

	assign rsp_valid      = rsp_valid_q;
	assign rsp            = rsp_q;
	assign stat.pipe_busy = v_s1 || v_s2;
	assign stat.rsp_free  = !rsp_valid_q || !rsp_stall;

endmodule

// ===== src/mma_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: request acceptance and the row, column, inner-index sequencer.
module mma_ctrl #(
	parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  logic [mma_pkg::FUNC_W-1:0]   req_func,
	output logic                         req_stall,
	input  logic [$clog2(MAX_DIM+1)-1:0] rows_eff,
	input  logic [$clog2(MAX_DIM+1)-1:0] mids_eff,
	input  logic [$clog2(MAX_DIM+1)-1:0] cols_eff,
	input  mma_pkg::dp_stat_t            stat,
	output mma_pkg::ctrl_cmd_t           cmd,
	output logic [$clog2(MAX_DIM)-1:0]   row_idx,
	output logic [$clog2(MAX_DIM)-1:0]   col_idx,
	output logic [$clog2(MAX_DIM)-1:0]   mid_idx
);
	import mma_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIM);
	localparam int CNT_W = $clog2(MAX_DIM + 1);

	typedef enum logic [1:0] {IDLE, RUN, DRAIN, RESP} state_t;

	state_t           state_q;
	logic [DIM_W-1:0] i_q, j_q, k_q;
	logic             k_last, j_last, i_last;

	always_comb begin
		k_last = CNT_W'(k_q) == mids_eff - CNT_W'(1);
		j_last = CNT_W'(j_q) == cols_eff - CNT_W'(1);
		i_last = CNT_W'(i_q) == rows_eff - CNT_W'(1);

		cmd.accept      = (state_q == IDLE) && req_valid;
		cmd.mac_go      = (state_q == RUN);
		cmd.mac_first   = (state_q == RUN) && (k_q == '0);
		cmd.mac_last    = (state_q == RUN) && k_last;
		cmd.result_load = (state_q == RESP) && stat.rsp_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (req_valid) begin
						state_q <= (req_func == FN_COMPUTE) ? RUN : RESP;
					end
				end
				RUN: begin
					// advance inner index, then column, then row
					if (k_last) begin
						k_q <= '0;
						if (j_last) begin
							j_q <= '0;
							if (i_last) begin
								i_q     <= '0;
								state_q <= DRAIN;
							end else begin
								i_q <= i_q + DIM_W'(1);
							end
						end else begin
							j_q <= j_q + DIM_W'(1);
						end
					end else begin
						k_q <= k_q + DIM_W'(1);
					end
				end
				DRAIN: begin
					if (!stat.pipe_busy) state_q <= RESP;
				end
				RESP: begin
					if (stat.rsp_free) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != IDLE);
	assign row_idx   = i_q;
	assign col_idx   = j_q;
	assign mid_idx   = k_q;

endmodule

// ===== src/matrix_multiply_accumulate_unit.sv =====
`timescale 1ns / 1ps
// Top level of the matrix multiply-accumulate unit (C = A*B + C).
//
//  channel   handshake               payload     role
//  request   req_valid / req_stall   req         write A/B/C, compute, read C
//  response  rsp_valid / rsp_stall   rsp         one per request
//  config    cfg_we                  cfg_index   row, inner, column counts
//                                    cfg_data
//
// Writes, reads and rejected requests are accepted, then their response is loaded.
// A compute request runs one multiply-accumulate per cycle over rows*inner*cols
// steps, set by the single read port of each A and B store, then a three-stage
// pipeline drain and the response load.
// Reset clears control state and the saturation flag; the stores are not cleared.
// A stalled response holds in its register; the next request is still accepted.
module matrix_multiply_accumulate_unit #(
	parameter int MAX_DIM   = mma_pkg::MAX_DIM_DEF,
	parameter int ELEM_BITS = mma_pkg::ELEM_BITS_DEF,
	parameter int ACC_BITS  = mma_pkg::ACC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  mma_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output mma_pkg::rsp_t                 rsp,
	input  logic                          cfg_we,
	input  logic [mma_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mma_pkg::CFG_W-1:0]     cfg_data
);
	import mma_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIM);
	localparam int CNT_W = $clog2(MAX_DIM + 1);

	ctrl_cmd_t        cmd;
	dp_stat_t         stat;
	logic [DIM_W-1:0] row_idx, col_idx, mid_idx;
	logic [CNT_W-1:0] rows_eff, mids_eff, cols_eff;

	mma_ctrl #(
		.MAX_DIM(MAX_DIM)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_func  (req.func),
		.req_stall (req_stall),
		.rows_eff  (rows_eff),
		.mids_eff  (mids_eff),
		.cols_eff  (cols_eff),
		.stat      (stat),
		.cmd       (cmd),
		.row_idx   (row_idx),
		.col_idx   (col_idx),
		.mid_idx   (mid_idx)
	);

	mma_dp #(
		.MAX_DIM   (MAX_DIM),
		.ELEM_BITS (ELEM_BITS),
		.ACC_BITS  (ACC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.row_idx   (row_idx),
		.col_idx   (col_idx),
		.mid_idx   (mid_idx),
		.rows_eff  (rows_eff),
		.mids_eff  (mids_eff),
		.cols_eff  (cols_eff),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== src/mma_chk.sv =====
`timescale 1ns / 1ps
// Port-level checks of the matrix multiply-accumulate unit, bound to the top level.
module mma_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input mma_pkg::rsp_t rsp
);
	import mma_pkg::*;

	// one request at a time: after an accept the unit is busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted twice in a row");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	a_compute_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.done_res |-> rsp.read_value == '0 && rsp.status != ST_RANGE)
		else $error("compute response carries data or range error");

	a_range_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_RANGE |-> rsp.read_value == '0 && !rsp.done_res)
		else $error("rejected request carries data");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status == ST_OK || rsp.status == ST_RANGE || rsp.status == ST_SAT)
		else $error("unknown status code");

endmodule

bind matrix_multiply_accumulate_unit mma_chk u_mma_chk (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the matrix multiply-accumulate unit with a C = A*B + C predictor.
module tb_top;
	import mma_pkg::*;

	localparam int DIM = MAX_DIM_DEF;
	localparam longint ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint ACC_MIN = -ACC_MAX - 1;
	localparam int IDLE_PCT = 38;
	localparam int RANDOM_ITEMS = 120;

	// Function codes the block does not define
	localparam logic [FUNC_W-1:0] FN_SPARE0 = 3'd5;
	localparam logic [FUNC_W-1:0] FN_SPARE1 = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE2 = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_ROW_COUNT;
	logic [CFG_W-1:0] cfg_data = '0;

	matrix_multiply_accumulate_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor state
	logic signed [FACTOR_W-1:0] a_mem [DIM*DIM];
	logic signed [FACTOR_W-1:0] b_mem [DIM*DIM];
	logic signed [ACC_IN_W-1:0] c_mem [DIM*DIM];
	bit sat_flag = 1'b0;
	logic [CFG_W-1:0] dim_reg [3] = '{default: CFG_RESET};
	logic [CFG_IDX_W-1:0] dim_sel [3] = '{CFG_ROW_COUNT, CFG_INNER_COUNT, CFG_COLUMN_COUNT};

	// Stimulus side: which entries the queued requests have filled
	bit a_set [DIM*DIM];
	bit b_set [DIM*DIM];
	bit c_set [DIM*DIM];
	int g_rows = DIM;
	int g_mids = DIM;
	int g_cols = DIM;

	req_t req_backlog [$];
	rsp_t awaited_rsp [$];
	rsp_t rsp_want;
	int errors = 0;
	int req_taken = 0;
	int queued = 0;
	int hold_left = 0;
	bit held_once = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int eff_dim(input logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > DIM)
			return DIM;
		return int'(v);
	endfunction

	function automatic void addr_limits(input logic [FUNC_W-1:0] fn, input int rows,
			input int mids, input int cols, output int rlim, output int clim);
		case (fn)
			FN_WRITE_A: begin rlim = rows; clim = mids; end
			FN_WRITE_B: begin rlim = mids; clim = cols; end
			FN_WRITE_C, FN_READ_C: begin rlim = rows; clim = cols; end
			default: begin rlim = 0; clim = 0; end
		endcase
	endfunction

	// Apply one accepted request to the predictor and return the response it owes
	function automatic rsp_t gemm_response(input req_t r);
		int rows, mids, cols, rlim, clim, idx;
		longint acc, prod;
		rsp_t o;
		rows = eff_dim(dim_reg[CFG_ROW_COUNT]);
		mids = eff_dim(dim_reg[CFG_INNER_COUNT]);
		cols = eff_dim(dim_reg[CFG_COLUMN_COUNT]);
		o = '0;
		addr_limits(r.func, rows, mids, cols, rlim, clim);
		idx = r.row_index * DIM + r.col_index;
		if (r.func == FN_COMPUTE) begin
			sat_flag = 1'b0;
			for (int i = 0; i < rows; i++)
				for (int j = 0; j < cols; j++) begin
					acc = longint'(c_mem[i*DIM+j]);
					// accumulate in ascending k, clamping after every add
					for (int k = 0; k < mids; k++) begin
						prod = longint'(a_mem[i*DIM+k]) * longint'(b_mem[k*DIM+j]);
						if (prod > 0 && acc > ACC_MAX - prod) begin
							acc = ACC_MAX;
							sat_flag = 1'b1;
						end else if (prod < 0 && acc < ACC_MIN - prod) begin
							acc = ACC_MIN;
							sat_flag = 1'b1;
						end else begin
							acc += prod;
						end
					end
					c_mem[i*DIM+j] = acc[ACC_IN_W-1:0];
				end
			o.done_res = 1'b1;
			o.status = sat_flag ? ST_SAT : ST_OK;
		end else if (r.func > FN_READ_C || r.row_index >= rlim || r.col_index >= clim) begin
			o.status = ST_RANGE;
		end else begin
			case (r.func)
				FN_WRITE_A: a_mem[idx] = r.factor_value;
				FN_WRITE_B: b_mem[idx] = r.factor_value;
				FN_WRITE_C: c_mem[idx] = r.acc_value;
				default: begin
					o.read_value = c_mem[idx];
					o.status = sat_flag ? ST_SAT : ST_OK;
				end
			endcase
		end
		return o;
	endfunction

	function automatic bit steady_window();
		return req_taken >= 100 && req_taken < 170;
	endfunction

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else if (!req_valid || !req_stall) begin
			if (req_valid) begin
				awaited_rsp.push_back(gemm_response(req));
				req_taken++;
			end
			if (req_backlog.size() != 0 && (steady_window() || $urandom_range(99) >= IDLE_PCT)) begin
				req <= req_backlog.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Response monitor and stall generator
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_rsp.size() == 0) begin
					$error("response with no request outstanding");
					errors++;
				end else begin
					rsp_want = awaited_rsp.pop_front();
					if (rsp.read_value !== rsp_want.read_value) begin
						$error("read_value: expected %0d, actual %0d", rsp_want.read_value,
							rsp.read_value);
						errors++;
					end
					if (rsp.status !== rsp_want.status) begin
						$error("status: expected %0d, actual %0d", rsp_want.status, rsp.status);
						errors++;
					end
					if (rsp.done_res !== rsp_want.done_res) begin
						$error("done_res: expected %0d, actual %0d", rsp_want.done_res,
							rsp.done_res);
						errors++;
					end
				end
			end
			// hold off once while requests pile up so the block backs up
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (!held_once && req_backlog.size() > 8) begin
				held_once = 1'b1;
				hold_left = 120;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= !steady_window() && $urandom_range(99) < IDLE_PCT;
			end
		end
	end

	function automatic logic signed [FACTOR_W-1:0] rand_factor();
		case ($urandom_range(7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			default: return FACTOR_W'($urandom);
		endcase
	endfunction

	// Bias accumulators toward the rails so that saturation shows up often
	function automatic logic signed [ACC_IN_W-1:0] rand_acc();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(3))
			0: return ACC_IN_W'(ACC_MAX - longint'($urandom_range(32'h7FFF_FFFF)));
			1: return ACC_IN_W'(ACC_MIN + longint'($urandom_range(32'h7FFF_FFFF)));
			default: return raw[ACC_IN_W-1:0];
		endcase
	endfunction

	task automatic queue_req(input logic [FUNC_W-1:0] fn, input int row, input int col,
			input logic signed [FACTOR_W-1:0] fv, input logic signed [ACC_IN_W-1:0] av);
		req_t r;
		int rlim, clim;
		r.func = fn;
		r.row_index = row[INDEX_W-1:0];
		r.col_index = col[INDEX_W-1:0];
		r.factor_value = fv;
		r.acc_value = av;
		addr_limits(fn, g_rows, g_mids, g_cols, rlim, clim);
		if (row < rlim && col < clim) begin
			case (fn)
				FN_WRITE_A: a_set[row*DIM+col] = 1'b1;
				FN_WRITE_B: b_set[row*DIM+col] = 1'b1;
				FN_WRITE_C: c_set[row*DIM+col] = 1'b1;
				default: ;
			endcase
		end
		req_backlog.push_back(r);
		queued++;
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (req_backlog.size() != 0 || req_valid || awaited_rsp.size() != 0);
	endtask

	task automatic set_dims(input logic [CFG_W-1:0] rv, input logic [CFG_W-1:0] iv,
			input logic [CFG_W-1:0] cv);
		logic [CFG_W-1:0] vals [3];
		vals = '{rv, iv, cv};
		wait_idle();
		for (int n = 0; n < 3; n++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= dim_sel[n];
			cfg_data <= vals[n];
			dim_reg[dim_sel[n]] = vals[n];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		g_rows = eff_dim(rv);
		g_mids = eff_dim(iv);
		g_cols = eff_dim(cv);
	endtask

	// One phase: new sizes, fill every operand still missing, mix, compute, read back
	task automatic run_phase(input logic [CFG_W-1:0] rv, input logic [CFG_W-1:0] iv,
			input logic [CFG_W-1:0] cv);
		logic [FUNC_W-1:0] fn;
		int rlim, clim, row, col;
		set_dims(rv, iv, cv);
		for (int i = 0; i < g_rows; i++)
			for (int k = 0; k < g_mids; k++)
				if (!a_set[i*DIM+k])
					queue_req(FN_WRITE_A, i, k, rand_factor(), rand_acc());
		for (int k = 0; k < g_mids; k++)
			for (int j = 0; j < g_cols; j++)
				if (!b_set[k*DIM+j])
					queue_req(FN_WRITE_B, k, j, rand_factor(), rand_acc());
		for (int i = 0; i < g_rows; i++)
			for (int j = 0; j < g_cols; j++)
				if (!c_set[i*DIM+j])
					queue_req(FN_WRITE_C, i, j, rand_factor(), rand_acc());
		repeat ($urandom_range(2, 10)) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: begin
					fn = FUNC_W'($urandom_range(FN_WRITE_A, FN_WRITE_C));
					addr_limits(fn, g_rows, g_mids, g_cols, rlim, clim);
					queue_req(fn, $urandom_range(rlim - 1), $urandom_range(clim - 1),
						rand_factor(), rand_acc());
				end
				5, 6: queue_req(FN_READ_C, $urandom_range(g_rows - 1),
					$urandom_range(g_cols - 1), rand_factor(), rand_acc());
				default: begin
					fn = FUNC_W'($urandom_range(7));
					row = $urandom_range(DIM - 1);
					col = $urandom_range(DIM - 1);
					// never read an accumulator that was not written
					addr_limits(fn, g_rows, g_mids, g_cols, rlim, clim);
					if (fn == FN_READ_C && row < rlim && col < clim && !c_set[row*DIM+col])
						fn = FN_WRITE_C;
					queue_req(fn, row, col, rand_factor(), rand_acc());
				end
			endcase
		end
		repeat ($urandom_range(1, 2))
			queue_req(FN_COMPUTE, $urandom_range(DIM - 1), $urandom_range(DIM - 1),
				rand_factor(), rand_acc());
		repeat ($urandom_range(1, 4))
			queue_req(FN_READ_C, $urandom_range(g_rows - 1), $urandom_range(g_cols - 1),
				rand_factor(), rand_acc());
	endtask

	initial begin
		int random_start;
		logic [CFG_W-1:0] rv, iv, cv;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset sizes: corner indices and undefined functions
		queue_req(FN_WRITE_A, DIM - 1, DIM - 1, 16'sh7FFF, '0);
		queue_req(FN_WRITE_B, DIM - 1, DIM - 1, 16'sh8000, '1);
		queue_req(FN_WRITE_C, DIM - 1, DIM - 1, 16'sh0000, ACC_IN_W'(ACC_MAX));
		queue_req(FN_READ_C, DIM - 1, DIM - 1, 16'sh0000, '0);
		queue_req(FN_SPARE0, DIM - 1, DIM - 1, 16'sh7FFF, '1);
		queue_req(FN_SPARE1, 0, 0, 16'sh0000, '0);
		queue_req(FN_SPARE2, DIM - 1, 0, 16'sh8000, ACC_IN_W'(ACC_MIN));

		// Zero counts behave as one: everything past entry 0 is out of range
		set_dims('0, '0, '0);
		queue_req(FN_WRITE_A, 0, 1, 16'sh1234, '0);
		queue_req(FN_WRITE_B, 1, 0, 16'sh1234, '0);
		queue_req(FN_WRITE_C, 0, DIM - 1, 16'sh0000, 48'sh1);
		queue_req(FN_READ_C, DIM - 1, DIM - 1, 16'sh0000, '0);
		// Positive overflow
		queue_req(FN_WRITE_A, 0, 0, 16'sh8000, '0);
		queue_req(FN_WRITE_B, 0, 0, 16'sh8000, '0);
		queue_req(FN_WRITE_C, 0, 0, 16'sh0000, ACC_IN_W'(ACC_MAX - 5));
		queue_req(FN_COMPUTE, 0, 0, 16'sh0000, '0);
		queue_req(FN_READ_C, 0, 0, 16'sh0000, '0);
		// Negative overflow
		queue_req(FN_WRITE_B, 0, 0, 16'sh7FFF, '0);
		queue_req(FN_WRITE_C, 0, 0, 16'sh0000, ACC_IN_W'(ACC_MIN + 3));
		queue_req(FN_COMPUTE, 0, 0, 16'sh0000, '0);
		// Clean compute clears the flag
		queue_req(FN_WRITE_A, 0, 0, 16'sh7FFF, '0);
		queue_req(FN_WRITE_C, 0, 0, 16'sh0000, '0);
		queue_req(FN_COMPUTE, 0, 0, 16'sh0000, '0);
		queue_req(FN_READ_C, 0, 0, 16'sh0000, '0);

		random_start = queued;
		run_phase(5'd31, 5'd1, 5'd1);
		run_phase(5'd1, 5'd16, 5'd1);
		run_phase(5'd1, 5'd1, 5'd17);
		run_phase(5'd2, 5'd2, 5'd3);
		while (queued < random_start + RANDOM_ITEMS) begin
			rv = CFG_W'($urandom_range(4));
			iv = CFG_W'($urandom_range(4));
			cv = CFG_W'($urandom_range(4));
			case ($urandom_range(5))
				0: rv = CFG_W'($urandom_range(16, 31));
				1: iv = CFG_W'($urandom_range(16, 31));
				2: cv = CFG_W'($urandom_range(16, 31));
				default: ;
			endcase
			run_phase(rv, iv, cv);
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
